[hdl/slbp_pkg.sv]
// slbp_pkg: shared types and constants for the status LED breathing PWM block.
// Holds field widths, status class codes, register indexes, reset values and
// the request/response structs of the serial divider. No dependencies.
package slbp_pkg;

    localparam int PER_W = 16;          // period and steps registers
    localparam int CNT_W = 20;          // tick counter, wrap and timeout
    localparam int DIV_W = 20;          // divider dividend / quotient
    localparam int DVS_W = 17;          // divider divisor / remainder
    localparam int CLS_W = 3;
    localparam int IDX_W = 3;

    // status class codes
    localparam logic [CLS_W-1:0] CLS_IDLE      = 3'd0;
    localparam logic [CLS_W-1:0] CLS_UPLOAD    = 3'd1;
    localparam logic [CLS_W-1:0] CLS_DOWNLOAD  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_BOOT_IDLE = 3'd3;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_SLOW_PERIOD  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SLOW_STEPS   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_FAST_PERIOD  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_FAST_STEPS   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_WRAP_LIMIT   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd5;

    // register reset values
    localparam logic [PER_W-1:0] RST_SLOW_PERIOD  = 16'd50;
    localparam logic [PER_W-1:0] RST_SLOW_STEPS   = 16'd100;
    localparam logic [PER_W-1:0] RST_FAST_PERIOD  = 16'd25;
    localparam logic [PER_W-1:0] RST_FAST_STEPS   = 16'd50;
    localparam logic [CNT_W-1:0] RST_WRAP_LIMIT   = 20'd500000;
    localparam logic [CNT_W-1:0] RST_IDLE_TIMEOUT = 20'd60000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

endpackage

[hdl/slbp_div.sv]
// slbp_div: restoring serial divider, one quotient bit per cycle.
// Depends on slbp_pkg (request/response structs, widths).
module slbp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slbp_pkg::t_div_req i_req,
    output slbp_pkg::t_div_rsp o_rsp
);
    import slbp_pkg::*;

    localparam int CYC_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CYC_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[DIV_W-1]};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        w_diff  = w_shift - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CYC_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

[hdl/slbp_breathe.sv]
// slbp_breathe: sequencer that evaluates one triangular breathing PWM bit
// through up to four passes of the shared serial divider. Depends on slbp_pkg, slbp_div.
module slbp_breathe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [slbp_pkg::PER_W-1:0] i_p,
    input  logic [slbp_pkg::PER_W-1:0] i_s,
    input  logic [slbp_pkg::CNT_W-1:0] i_c,
    output logic                       o_done,
    output logic                       o_lit
);
    import slbp_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE, B_CP, B_SP, B_M, B_DUTY, B_FIN
    } t_bstate;

    t_bstate          r_state;
    t_div_req         r_req;
    t_div_rsp         w_rsp;
    logic             r_done;
    logic             r_lit;
    logic             r_mirror;
    logic [DIV_W-1:0] r_k;        // c / p
    logic [PER_W-1:0] r_r;        // c mod p
    logic [PER_W-1:0] r_q;        // s / p
    logic [PER_W-1:0] r_duty;

    logic [DVS_W-1:0] w_s17;
    logic [DVS_W-1:0] w_m;        // (c / p) mod 2s
    logic [DVS_W-1:0] w_ms;       // (c / p) mod s
    logic             w_mirror;
    logic [PER_W-1:0] w_pd;
    logic             w_lit;

    slbp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_s17    = {1'b0, i_s};
        w_m      = w_rsp.rem;
        // second half of the 2*p*s cycle: phase = m*p + r > s*p
        w_mirror = (w_m > w_s17) || ((w_m == w_s17) && (r_r != '0));
        w_ms     = (w_m >= w_s17) ? (w_m - w_s17) : w_m;
        w_pd     = i_p - r_duty;
        if (r_mirror) begin
            w_lit = (r_duty > i_p) ? 1'b0 : (r_r > w_pd);
        end else begin
            w_lit = (r_r > r_duty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_req.start <= 1'b0;
            r_done      <= 1'b0;
            r_lit       <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            r_done      <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        if ((i_p == '0) || (i_s == '0)) begin
                            r_lit  <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_req.start    <= 1'b1;
                            r_req.dividend <= i_c;
                            r_req.divisor  <= {1'b0, i_p};
                            r_state        <= B_CP;
                        end
                    end
                end
                B_CP: begin
                    if (w_rsp.done) begin
                        r_k            <= w_rsp.quo;
                        r_r            <= w_rsp.rem[PER_W-1:0];
                        r_req.start    <= 1'b1;
                        r_req.dividend <= {{(DIV_W-PER_W){1'b0}}, i_s};
                        r_req.divisor  <= {1'b0, i_p};
                        r_state        <= B_SP;
                    end
                end
                B_SP: begin
                    if (w_rsp.done) begin
                        r_q            <= w_rsp.quo[PER_W-1:0];
                        r_req.start    <= 1'b1;
                        r_req.dividend <= r_k;
                        r_req.divisor  <= {i_s, 1'b0};
                        r_state        <= B_M;
                    end
                end
                B_M: begin
                    if (w_rsp.done) begin
                        r_mirror <= w_mirror;
                        if (r_q == '0) begin
                            r_duty  <= '0;
                            r_state <= B_FIN;
                        end else begin
                            r_req.start    <= 1'b1;
                            r_req.dividend <= {{(DIV_W-PER_W){1'b0}}, w_ms[PER_W-1:0]};
                            r_req.divisor  <= {1'b0, r_q};
                            r_state        <= B_DUTY;
                        end
                    end
                end
                B_DUTY: begin
                    if (w_rsp.done) begin
                        r_duty  <= w_rsp.quo[PER_W-1:0];
                        r_state <= B_FIN;
                    end
                end
                B_FIN: begin
                    r_lit   <= w_lit;
                    r_done  <= 1'b1;
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_lit  = r_lit;

endmodule

[hdl/status_led_breathing_pwm.sv]
// status_led_breathing_pwm: top level of the two-LED breathing status driver.
// Depends on slbp_pkg, slbp_breathe (which holds slbp_div).
//
// Usage:
//   Input channel (i_valid / o_ready, i_status_class): one transaction per
//   LED tick, carrying the device status class. Output channel (o_valid /
//   i_ready): one transaction per tick with o_blue_on, o_red_on and
//   o_jump_request.
//   Config port (i_cfg_we, i_cfg_idx, i_cfg_data): single-cycle writes,
//   0 slow period, 1 slow steps, 2 fast period, 3 fast steps, 4 wrap limit,
//   5 idle timeout; other indexes are ignored. Write only while idle.
//   Divider passes (acceptance to o_valid): a breathing LED takes four
//   passes of the serial divider, three when steps are below the period,
//   none when its period or steps register is 0. Uploading runs two LED
//   evaluations back to back; bootloader idle needs none. The single
//   shared divider serves every pass.
//   One tick is in work at a time; o_ready drops from acceptance until its
//   result is moved into the output register.
//   Stall: a finished result waits in the output register; the next tick
//   can be accepted meanwhile, and its result waits in the block until
//   the output register frees up.
//   Reset (synchronous, i_rst_n low): tick counter 0, registers to defaults,
//   no result pending.
module status_led_breathing_pwm (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [slbp_pkg::CLS_W-1:0] i_status_class,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_blue_on,
    output logic                       o_red_on,
    output logic                       o_jump_request,
    input  logic                       i_cfg_we,
    input  logic [slbp_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [slbp_pkg::CNT_W-1:0] i_cfg_data
);
    import slbp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE, S_RUN1, S_RUN2, S_HOLD
    } t_state;

    // configuration
    logic [PER_W-1:0] r_slow_period;
    logic [PER_W-1:0] r_slow_steps;
    logic [PER_W-1:0] r_fast_period;
    logic [PER_W-1:0] r_fast_steps;
    logic [CNT_W-1:0] r_wrap_limit;
    logic [CNT_W-1:0] r_idle_timeout;

    // control
    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic             r_bstart;
    logic             r_sel_fast;
    logic             r_out_valid;

    // payload
    logic [CLS_W-1:0] r_cls;
    logic [CNT_W-1:0] r_c;
    logic             r_pblue;
    logic             r_pred;
    logic             r_pjump;
    logic             r_blue;
    logic             r_red;
    logic             r_jump;

    logic             w_accept;
    logic [CNT_W-1:0] w_cnt_clr;
    logic             w_load;
    logic             w_bdone;
    logic             w_blit;
    logic [PER_W-1:0] w_p;
    logic [PER_W-1:0] w_s;

    assign w_accept  = i_valid && o_ready;
    // counter cleared once it runs past the wrap limit
    assign w_cnt_clr = (r_count > r_wrap_limit) ? '0 : r_count;
    assign w_load    = (r_state == S_HOLD) && (!r_out_valid || i_ready);
    assign w_p       = r_sel_fast ? r_fast_period : r_slow_period;
    assign w_s       = r_sel_fast ? r_fast_steps  : r_slow_steps;

    slbp_breathe u_breathe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_bstart),
        .i_p     (w_p),
        .i_s     (w_s),
        .i_c     (r_c),
        .o_done  (w_bdone),
        .o_lit   (w_blit)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_period  <= RST_SLOW_PERIOD;
            r_slow_steps   <= RST_SLOW_STEPS;
            r_fast_period  <= RST_FAST_PERIOD;
            r_fast_steps   <= RST_FAST_STEPS;
            r_wrap_limit   <= RST_WRAP_LIMIT;
            r_idle_timeout <= RST_IDLE_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLOW_PERIOD:  r_slow_period  <= i_cfg_data[PER_W-1:0];
                CFG_SLOW_STEPS:   r_slow_steps   <= i_cfg_data[PER_W-1:0];
                CFG_FAST_PERIOD:  r_fast_period  <= i_cfg_data[PER_W-1:0];
                CFG_FAST_STEPS:   r_fast_steps   <= i_cfg_data[PER_W-1:0];
                CFG_WRAP_LIMIT:   r_wrap_limit   <= i_cfg_data;
                CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tick sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_bstart    <= 1'b0;
            r_sel_fast  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_bstart <= 1'b0;

            if (w_load) begin
                r_out_valid <= 1'b1;
                r_blue      <= r_pblue;
                r_red       <= r_pred;
                r_jump      <= r_pjump;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cls   <= i_status_class;
                        r_c     <= r_count;
                        r_pjump <= (i_status_class == CLS_BOOT_IDLE) &&
                                   (w_cnt_clr > r_idle_timeout);
                        r_count <= w_cnt_clr + 1'b1;
                        r_pred  <= 1'b0;
                        if (i_status_class == CLS_BOOT_IDLE) begin
                            r_pblue <= 1'b1;
                            r_state <= S_HOLD;
                        end else begin
                            r_sel_fast <= (i_status_class == CLS_DOWNLOAD);
                            r_bstart   <= 1'b1;
                            r_state    <= S_RUN1;
                        end
                    end
                end
                S_RUN1: begin
                    if (w_bdone) begin
                        r_pblue <= w_blit;
                        if (r_cls == CLS_UPLOAD) begin
                            r_sel_fast <= 1'b1;
                            r_bstart   <= 1'b1;
                            r_state    <= S_RUN2;
                        end else begin
                            // error and unused codes light red like blue
                            if ((r_cls != CLS_IDLE) && (r_cls != CLS_DOWNLOAD)) begin
                                r_pred <= w_blit;
                            end
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_RUN2: begin
                    if (w_bdone) begin
                        r_pred  <= w_blit;
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_blue_on      = r_blue;
    assign o_red_on       = r_red;
    assign o_jump_request = r_jump;

    // one tick in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("accepted a transaction while one was in work");

    // counter steps by one on each tick at or below the wrap limit
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_count <= r_wrap_limit)) |=> (r_count == $past(r_count) + 20'd1))
        else $error("tick counter did not advance by one");

    // the LED evaluator only finishes while the sequencer waits for it
    a_bdone_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bdone |-> (r_state == S_RUN1 || r_state == S_RUN2))
        else $error("LED evaluation finished outside a run state");

    // jump request only in bootloader idle
    a_jump_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && r_cls != CLS_BOOT_IDLE) |-> !r_pjump)
        else $error("jump request outside bootloader idle");

    // a pending result is moved only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!o_valid || i_ready))
        else $error("output register overwritten");

endmodule
